// File: src/cpu_alu_with_flags_top_macros.svh
// Assertion macros for the ALU block
`ifndef CPU_ALU_WITH_FLAGS_TOP_MACROS_SVH
`define CPU_ALU_WITH_FLAGS_TOP_MACROS_SVH

`ifndef SYNTH
`define CPUALU_ASSERT_NOW(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cpualu check failed: same-cycle implication");
`define CPUALU_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cpualu check failed: next-cycle implication");
`else
`define CPUALU_ASSERT_NOW(name, clk, rst, ante, cons)
`define CPUALU_ASSERT_NEXT(name, clk, rst, ante, cons)
`endif

`endif

// File: src/cpualu_pkg.sv
package cpualu_pkg;

  localparam logic [4:0] MODE_ADD  = 5'd0;
  localparam logic [4:0] MODE_ADC  = 5'd1;
  localparam logic [4:0] MODE_SUB  = 5'd2;
  localparam logic [4:0] MODE_SBC  = 5'd3;
  localparam logic [4:0] MODE_AND  = 5'd4;
  localparam logic [4:0] MODE_XOR  = 5'd5;
  localparam logic [4:0] MODE_OR   = 5'd6;
  localparam logic [4:0] MODE_CP   = 5'd7;
  localparam logic [4:0] MODE_INC  = 5'd8;
  localparam logic [4:0] MODE_DEC  = 5'd9;
  localparam logic [4:0] MODE_DAA  = 5'd10;
  localparam logic [4:0] MODE_RLC  = 5'd11;
  localparam logic [4:0] MODE_SRL  = 5'd18;
  localparam logic [4:0] MODE_RLCA = 5'd19;
  localparam logic [4:0] MODE_RRA  = 5'd22;
  localparam logic [4:0] MODE_BIT  = 5'd23;
  localparam logic [4:0] MODE_RES  = 5'd24;
  localparam logic [4:0] MODE_SET  = 5'd25;

  localparam logic [2:0] SH_RLC  = 3'd0;
  localparam logic [2:0] SH_RRC  = 3'd1;
  localparam logic [2:0] SH_RL   = 3'd2;
  localparam logic [2:0] SH_RR   = 3'd3;
  localparam logic [2:0] SH_SLA  = 3'd4;
  localparam logic [2:0] SH_SRA  = 3'd5;
  localparam logic [2:0] SH_SWAP = 3'd6;
  localparam logic [2:0] SH_SRL  = 3'd7;

  localparam int FLAG_Z = 3;
  localparam int FLAG_N = 2;
  localparam int FLAG_H = 1;
  localparam int FLAG_C = 0;

  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 16;

  typedef struct packed {
    logic [4:0] mode;
    logic [7:0] acc;
    logic [7:0] operand;
    logic [2:0] bit_index;
    logic [3:0] flags_in;
  } item_t;

  typedef struct packed {
    logic [7:0] result;
    logic [3:0] flags_out;
    logic       writes_result;
  } res_t;

endpackage

// File: src/cpu_alu_with_flags_top.sv
// 8-bit processor ALU with Z/N/H/C flags.
// Request channel (s_*): one request per handshake carries the operation code,
// accumulator, operand, bit index and the current flags. Each request yields
// exactly one response on the m_* channel with the result byte, the new flags
// and a write-back enable (clear for compare, bit test and unused codes).
// The handshake loads the input register; the ALU result register is loaded from it
// when the output side can advance, and m_tvalid rises once that register is full.
// Throughput: one request per cycle while m_tready is high; the ALU is a single pass
// of 8-bit add, shift and mux logic between the two registers.
// Reset (rst, synchronous, active high) empties both registers; no request is
// lost or created by reset release.
// When the receiver holds m_tready low, the result register holds its value,
// the input register may still fill, and s_tready drops only once both are
// occupied; the flow resumes without gaps when m_tready returns.
`include "cpu_alu_with_flags_top_macros.svh"

module cpu_alu_with_flags_top import cpualu_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // mode[4:0], acc[12:5], operand[20:13], bit_index[23:21], flags_in[27:24], zero[31:28]
  input  logic [IN_DATA_W-1:0]  s_tdata,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // result[7:0], flags_out[11:8], writes_result[12], zero[15:13]
  output logic [OUT_DATA_W-1:0] m_tdata
);

  logic  in_valid;
  logic  out_valid;
  logic  advance;
  item_t in_q;
  item_t in_item;
  res_t  core_res;
  res_t  out_q;

  assign in_item.mode      = s_tdata[4:0];
  assign in_item.acc       = s_tdata[12:5];
  assign in_item.operand   = s_tdata[20:13];
  assign in_item.bit_index = s_tdata[23:21];
  assign in_item.flags_in  = s_tdata[27:24];

  assign advance  = !out_valid || m_tready;
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s_tready) begin
        in_valid <= s_tvalid;
      end
      if (advance) begin
        out_valid <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_q <= in_item;
    end
    if (in_valid && advance) begin
      out_q <= core_res;
    end
  end

  cpualu_core u_core (
    .item (in_q),
    .res  (core_res)
  );

  assign m_tvalid = out_valid;
  assign m_tdata  = {3'b000, out_q.writes_result, out_q.flags_out, out_q.result};

  `CPUALU_ASSERT_NEXT(a_accept_fills, clk, rst, s_tvalid && s_tready, in_valid)
  `CPUALU_ASSERT_NEXT(a_stage_moves, clk, rst, in_valid && advance, out_valid)
  `CPUALU_ASSERT_NEXT(a_stage_holds, clk, rst, in_valid && !advance, in_valid && $stable(in_q))
  `CPUALU_ASSERT_NEXT(a_cp_no_write, clk, rst, in_valid && advance && in_q.mode == MODE_CP, !out_q.writes_result)
  `CPUALU_ASSERT_NEXT(a_incdec_keep_c, clk, rst, in_valid && advance && (in_q.mode == MODE_INC || in_q.mode == MODE_DEC), out_q.flags_out[FLAG_C] == $past(in_q.flags_in[FLAG_C]))

endmodule

// File: src/cpualu_core.sv
module cpualu_core import cpualu_pkg::*; (
  input  item_t item,
  output res_t  res
);

  function automatic logic [8:0] shift_op(input logic [2:0] kind, input logic [7:0] v,
                                          input logic cin);
    logic [8:0] o;
    begin
      case (kind)
        SH_RLC:  o = {v[7], v[6:0], v[7]};
        SH_RRC:  o = {v[0], v[0], v[7:1]};
        SH_RL:   o = {v[7], v[6:0], cin};
        SH_RR:   o = {v[0], cin, v[7:1]};
        SH_SLA:  o = {v[7], v[6:0], 1'b0};
        SH_SRA:  o = {v[0], v[7], v[7:1]};
        SH_SWAP: o = {1'b0, v[3:0], v[7:4]};
        SH_SRL:  o = {v[0], 1'b0, v[7:1]};
        default: o = 9'd0;
      endcase
      return o;
    end
  endfunction

  logic [7:0] a;
  logic [7:0] v;
  logic       fc;
  logic       fn;
  logic       fh;
  logic       cy_add;
  logic       cy_sub;
  logic [8:0] sum9;
  logic [4:0] half_add;
  logic [8:0] diff9;
  logic [4:0] half_sub;
  logic [7:0] inc_v;
  logic [7:0] dec_v;
  logic       daa_c;
  logic [7:0] daa_r1;
  logic [7:0] daa_r2;
  logic [4:0] sh_off;
  logic [4:0] rot_off;
  logic [2:0] sh_kind;
  logic [8:0] sh_out;
  logic [7:0] mask;
  logic [7:0] r;

  always_comb begin
    a      = item.acc;
    v      = item.operand;
    fc     = item.flags_in[FLAG_C];
    fn     = item.flags_in[FLAG_N];
    fh     = item.flags_in[FLAG_H];
    cy_add = (item.mode == MODE_ADC) & fc;
    cy_sub = (item.mode == MODE_SBC) & fc;

    sum9     = {1'b0, a} + {1'b0, v} + {8'd0, cy_add};
    half_add = {1'b0, a[3:0]} + {1'b0, v[3:0]} + {4'd0, cy_add};
    diff9    = {1'b0, a} - {1'b0, v} - {8'd0, cy_sub};
    half_sub = {1'b0, a[3:0]} - {1'b0, v[3:0]} - {4'd0, cy_sub};
    inc_v    = v + 8'd1;
    dec_v    = v - 8'd1;

    if (!fn) begin
      daa_c  = fc | (a > 8'h99);
      daa_r1 = daa_c ? a + 8'h60 : a;
      daa_r2 = (fh | (daa_r1[3:0] > 4'h9)) ? daa_r1 + 8'h06 : daa_r1;
    end else begin
      daa_c  = fc;
      daa_r1 = fc ? a - 8'h60 : a;
      daa_r2 = fh ? daa_r1 - 8'h06 : daa_r1;
    end

    sh_off  = item.mode - MODE_RLC;
    rot_off = item.mode - MODE_RLCA;
    sh_kind = (item.mode inside {[MODE_RLCA:MODE_RRA]}) ? rot_off[2:0] : sh_off[2:0];
    sh_out  = shift_op(sh_kind, v, fc);

    mask = 8'd1 << item.bit_index;

    r                 = 8'd0;
    res.flags_out     = item.flags_in;
    res.writes_result = 1'b1;

    case (item.mode) inside
      MODE_ADD, MODE_ADC: begin
        r             = sum9[7:0];
        res.flags_out = {r == 8'd0, 1'b0, half_add[4], sum9[8]};
      end
      MODE_SUB, MODE_SBC, MODE_CP: begin
        r             = diff9[7:0];
        res.flags_out = {r == 8'd0, 1'b1, half_sub[4], diff9[8]};
        if (item.mode == MODE_CP) begin
          res.writes_result = 1'b0;
        end
      end
      MODE_AND: begin
        r             = a & v;
        res.flags_out = {r == 8'd0, 1'b0, 1'b1, 1'b0};
      end
      MODE_XOR: begin
        r             = a ^ v;
        res.flags_out = {r == 8'd0, 3'b000};
      end
      MODE_OR: begin
        r             = a | v;
        res.flags_out = {r == 8'd0, 3'b000};
      end
      MODE_INC: begin
        r             = inc_v;
        res.flags_out = {r == 8'd0, 1'b0, v[3:0] == 4'hF, fc};
      end
      MODE_DEC: begin
        r             = dec_v;
        res.flags_out = {r == 8'd0, 1'b1, v[3:0] == 4'h0, fc};
      end
      MODE_DAA: begin
        r             = daa_r2;
        res.flags_out = {r == 8'd0, fn, 1'b0, daa_c};
      end
      [MODE_RLC:MODE_SRL]: begin
        r             = sh_out[7:0];
        res.flags_out = {r == 8'd0, 2'b00, sh_out[8]};
      end
      [MODE_RLCA:MODE_RRA]: begin
        r             = sh_out[7:0];
        res.flags_out = {3'b000, sh_out[8]};
      end
      MODE_BIT: begin
        r                 = v;
        res.flags_out     = {(v & mask) == 8'd0, 1'b0, 1'b1, fc};
        res.writes_result = 1'b0;
      end
      MODE_RES: begin
        r = v & ~mask;
      end
      MODE_SET: begin
        r = v | mask;
      end
      default: begin
        r                 = 8'd0;
        res.writes_result = 1'b0;
      end
    endcase

    res.result = r;
  end

endmodule
